// ----- sv/scaled_flipped_blit_address_gen_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scaled flipped blit address generator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCALED_FLIPPED_BLIT_ADDRESS_GEN_ASSERT_SVH
`define SCALED_FLIPPED_BLIT_ADDRESS_GEN_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never occur outside reset
`define SFB_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFB_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- sv/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared widths, register codes and types of the blit address generator.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int ROW_W    = 16;
    localparam int SW_W     = 12;
    localparam int IW_W     = 13;
    localparam int ORG_W    = 16;
    localparam int TGT_W    = 16;
    localparam int CFG_W    = 16;
    localparam int NUM_W    = 29;   // 16 x 13 product, divider dividend
    localparam int FPROD_W  = 29;   // 17 x 12 product
    localparam int FRAME_W  = 30;
    localparam int FAREA_W  = 24;
    localparam int SAREA_W  = 26;
    localparam int SY_W     = 31;
    localparam int SPROD_W  = 45;
    localparam int SRC_W    = 46;
    localparam int FIDX_W   = 22;
    localparam int SIDX_W   = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [2:0] {
        REG_SCREEN_W  = 3'd0,
        REG_SCREEN_H  = 3'd1,
        REG_IMAGE_W   = 3'd2,
        REG_IMAGE_H   = 3'd3,
        REG_ORIGIN_X  = 3'd4,
        REG_ORIGIN_Y  = 3'd5,
        REG_TARGET_W  = 3'd6,
        REG_TARGET_H  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SW_W-1:0]    screen_width;
        logic [SW_W-1:0]    screen_height;
        logic [IW_W-1:0]    image_width;
        logic [IW_W-1:0]    image_height;
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [TGT_W-1:0]   target_width;
        logic [TGT_W-1:0]   target_height;
        logic [FAREA_W-1:0] frame_area;
        logic [SAREA_W-1:0] source_area;
    } t_cfg;

    typedef struct packed {
        logic [NUM_W-1:0]   num_x;
        logic [NUM_W-1:0]   num_y;
        logic [FPROD_W-1:0] frame_prod;
        logic [ROW_W-1:0]   col;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_AW:0]   count;
    } t_fifo_st;

endpackage

// ----- sv/sfb_channels.sv -----
// ----------------------------------------------------------------------------
// sfb channels
// Valid/ready channels for destination pixels in and addresses out.
// ----------------------------------------------------------------------------
interface sfb_in_if;
    logic                     valid;
    logic                     ready;
    logic [sfb_pkg::ROW_W-1:0] dest_row;
    logic [sfb_pkg::ROW_W-1:0] dest_col;
    modport source (output valid, output dest_row, output dest_col, input ready);
    modport sink   (input valid, input dest_row, input dest_col, output ready);
endinterface

interface sfb_out_if;
    logic                      valid;
    logic                      ready;
    logic [sfb_pkg::FIDX_W-1:0] frame_index;
    logic [sfb_pkg::SIDX_W-1:0] source_index;
    logic                      write_enable;
    modport source (output valid, output frame_index, output source_index,
                    output write_enable, input ready);
    modport sink   (input valid, input frame_index, input source_index,
                    input write_enable, output ready);
endinterface

// ----- sv/scaled_flipped_blit_address_gen.sv -----
// ----------------------------------------------------------------------------
// scaled_flipped_blit_address_gen
// Nearest-neighbor scaled, vertically flipped blit address generator.
//
//   channel   dir  transfer                 payload
//   i_in      in   valid && ready           dest_row, dest_col
//   o_out     out  valid && ready           frame_index, source_index,
//                                           write_enable
//   i_cfg_*   in   i_cfg_we                 register index, data
//
// One transfer per clock sustained while the output is taken; the result
// passes the front register, queue write, the entry stage, the two 29-stage
// pipelined dividers (one quotient bit per stage), product and output stages.
// Reset is synchronous and clears all valid state; configuration returns
// to its reset values. A stalled output freezes the back pipe while the
// four-entry queue keeps taking transfers from the front.
// ----------------------------------------------------------------------------
`include "scaled_flipped_blit_address_gen_assert.svh"

module scaled_flipped_blit_address_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [sfb_pkg::CFG_W-1:0]   i_cfg_data,
    sfb_in_if.sink                      i_in,
    sfb_out_if.source                   o_out
);

    sfb_pkg::t_cfg     r_cfg;
    sfb_pkg::t_job     w_push_job;
    sfb_pkg::t_job     w_pop_job;
    sfb_pkg::t_fifo_st w_st;
    logic              w_push;
    logic              w_pop;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= sfb_pkg::SW_W'(1024);
            r_cfg.screen_height <= sfb_pkg::SW_W'(768);
            r_cfg.image_width   <= sfb_pkg::IW_W'(1);
            r_cfg.image_height  <= sfb_pkg::IW_W'(1);
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.target_width  <= sfb_pkg::TGT_W'(1);
            r_cfg.target_height <= sfb_pkg::TGT_W'(1);
            r_cfg.frame_area    <= sfb_pkg::FAREA_W'(1024 * 768);
            r_cfg.source_area   <= sfb_pkg::SAREA_W'(1);
        end else begin
            if (i_cfg_we) begin
                unique case (sfb_pkg::t_reg_idx'(i_cfg_idx))
                    sfb_pkg::REG_SCREEN_W: r_cfg.screen_width  <= i_cfg_data[11:0];
                    sfb_pkg::REG_SCREEN_H: r_cfg.screen_height <= i_cfg_data[11:0];
                    sfb_pkg::REG_IMAGE_W:  r_cfg.image_width   <= i_cfg_data[12:0];
                    sfb_pkg::REG_IMAGE_H:  r_cfg.image_height  <= i_cfg_data[12:0];
                    sfb_pkg::REG_ORIGIN_X: r_cfg.origin_x      <= i_cfg_data;
                    sfb_pkg::REG_ORIGIN_Y: r_cfg.origin_y      <= i_cfg_data;
                    sfb_pkg::REG_TARGET_W: r_cfg.target_width  <= i_cfg_data;
                    sfb_pkg::REG_TARGET_H: r_cfg.target_height <= i_cfg_data;
                    default: ;
                endcase
            end
            // track buffer sizes in registers that follow the configuration registers
            r_cfg.frame_area  <= sfb_pkg::FAREA_W'(r_cfg.screen_width)
                               * sfb_pkg::FAREA_W'(r_cfg.screen_height);
            r_cfg.source_area <= sfb_pkg::SAREA_W'(r_cfg.image_width)
                               * sfb_pkg::SAREA_W'(r_cfg.image_height);
        end
    end

    sfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (w_st.full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    sfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_st    (w_st)
    );

    sfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (w_pop_job),
        .i_st    (w_st),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // queue never overfills and never pops empty
    `SFB_NEVER(a_fifo_overflow, i_clk, i_rst_n, w_push && w_st.full, "queue push while full")
    `SFB_ASSERT(a_fifo_count, i_clk, i_rst_n, w_st.count <= 3'(sfb_pkg::FIFO_DEPTH), "queue count")
    // an accepted transfer is pushed or waits, never lost
    `SFB_ASSERT(a_front_hold, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready || w_push, "front dropped transfer")

endmodule

// ----- sv/sfb_front.sv -----
// ----------------------------------------------------------------------------
// sfb_front
// Accept destination pixels and form the products for both addresses.
// ----------------------------------------------------------------------------
module sfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfb_pkg::t_cfg i_cfg,
    sfb_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output sfb_pkg::t_job o_job
);

    logic          r_v;
    sfb_pkg::t_job r_job;
    logic          w_ready;

    // take a new transfer when the stage is empty or drains this cycle
    assign w_ready    = !r_v || !i_full;
    assign i_in.ready = w_ready;
    assign o_push     = r_v && !i_full;
    assign o_job      = r_job;

    // hold valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_ready) begin
            r_v <= i_in.valid;
        end
    end

    // form the products at full width
    always_ff @(posedge i_clk) begin
        if (w_ready && i_in.valid) begin
            r_job.num_x <= sfb_pkg::NUM_W'(i_in.dest_col)
                         * sfb_pkg::NUM_W'(i_cfg.image_width);
            r_job.num_y <= sfb_pkg::NUM_W'(i_in.dest_row)
                         * sfb_pkg::NUM_W'(i_cfg.image_height);
            r_job.frame_prod <= sfb_pkg::FPROD_W'({1'b0, i_cfg.origin_y} + {1'b0, i_in.dest_row})
                              * sfb_pkg::FPROD_W'(i_cfg.screen_width);
            r_job.col <= i_in.dest_col;
        end
    end

endmodule

// ----- sv/sfb_fifo.sv -----
// ----------------------------------------------------------------------------
// sfb_fifo
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sfb_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfb_pkg::t_job     i_job,
    input  logic              i_pop,
    output sfb_pkg::t_job     o_job,
    output sfb_pkg::t_fifo_st o_st
);

    sfb_pkg::t_job                 r_mem [sfb_pkg::FIFO_DEPTH];
    logic [sfb_pkg::FIFO_AW-1:0]   r_wp;
    logic [sfb_pkg::FIFO_AW-1:0]   r_rp;
    logic [sfb_pkg::FIFO_AW:0]     r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_st.count = r_cnt;
    assign o_st.full  = (r_cnt == (sfb_pkg::FIFO_AW+1)'(sfb_pkg::FIFO_DEPTH));
    assign o_st.empty = (r_cnt == '0);
    assign w_push = i_push && !o_st.full;
    assign w_pop  = i_pop && !o_st.empty;
    assign o_job  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ----- sv/sfb_div.sv -----
// ----------------------------------------------------------------------------
// sfb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sfb_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [sfb_pkg::NUM_W-1:0] i_num,
    input  logic [sfb_pkg::TGT_W-1:0] i_den,
    output logic [sfb_pkg::NUM_W-1:0] o_quo
);

    localparam int NW = sfb_pkg::NUM_W;
    localparam int DW = sfb_pkg::TGT_W;

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [NW-1:0] w_num_in;
        logic [DW:0]   w_trial;
        logic          w_ge;

        // shift in one dividend bit and try the subtract
        always_comb begin
            if (k == 0) begin
                w_rem_in = '0;
                w_num_in = i_num;
            end else begin
                w_rem_in = r_rem[(k == 0) ? 0 : k-1];
                w_num_in = r_num[(k == 0) ? 0 : k-1];
            end
            w_trial = {w_rem_in, w_num_in[NW-1]};
            w_ge    = (w_trial >= {1'b0, i_den});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DW'(w_trial - {1'b0, i_den}) : DW'(w_trial);
                r_num[k] <= {w_num_in[NW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_num[NW-1];

endmodule

// ----- sv/sfb_back.sv -----
// ----------------------------------------------------------------------------
// sfb_back
// Divide, flip and combine into the frame and source addresses.
// ----------------------------------------------------------------------------
module sfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfb_pkg::t_cfg     i_cfg,
    input  sfb_pkg::t_job     i_job,
    input  sfb_pkg::t_fifo_st i_st,
    output logic              o_pop,
    sfb_out_if.source         o_out
);

    localparam int NW = sfb_pkg::NUM_W;

    logic                         w_en;
    logic [sfb_pkg::TGT_W-1:0]    w_den_x;
    logic [sfb_pkg::TGT_W-1:0]    w_den_y;
    logic [sfb_pkg::FRAME_W-1:0]  w_frame;

    // entry stage
    logic                         r_v0;
    logic [NW-1:0]                r_num_x;
    logic [NW-1:0]                r_num_y;
    logic [sfb_pkg::FIDX_W-1:0]   r_fidx0;
    logic                         r_fok0;

    // delay line beside the dividers
    logic                         r_vd    [NW];
    logic [sfb_pkg::FIDX_W-1:0]   r_fidx_d[NW];
    logic                         r_fok_d [NW];

    logic [NW-1:0]                w_qx;
    logic [NW-1:0]                w_qy;
    logic signed [sfb_pkg::SY_W-1:0] w_sy;

    // product stage
    logic                         r_vm;
    logic signed [sfb_pkg::SPROD_W-1:0] r_sprod;
    logic [NW-1:0]                r_sx;
    logic [sfb_pkg::FIDX_W-1:0]   r_fidxm;
    logic                         r_fokm;

    logic signed [sfb_pkg::SRC_W-1:0] w_src;

    // output register
    logic                         r_ov;
    logic [sfb_pkg::FIDX_W-1:0]   r_fidx;
    logic [sfb_pkg::SIDX_W-1:0]   r_sidx;
    logic                         r_we;

    // advance the whole pipe unless the result is held
    assign w_en  = !r_ov || o_out.ready;
    assign o_pop = w_en && !i_st.empty;

    assign w_den_x = (i_cfg.target_width  == '0) ? sfb_pkg::TGT_W'(1) : i_cfg.target_width;
    assign w_den_y = (i_cfg.target_height == '0) ? sfb_pkg::TGT_W'(1) : i_cfg.target_height;

    assign w_frame = sfb_pkg::FRAME_W'(i_job.frame_prod)
                   + sfb_pkg::FRAME_W'(i_cfg.origin_x)
                   + sfb_pkg::FRAME_W'(i_job.col);

    // entry: finish the frame address and check it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= !i_st.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_x <= i_job.num_x;
            r_num_y <= i_job.num_y;
            r_fidx0 <= w_frame[sfb_pkg::FIDX_W-1:0];
            r_fok0  <= (w_frame < sfb_pkg::FRAME_W'(i_cfg.frame_area));
        end
    end

    sfb_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_x),
        .i_den (w_den_x),
        .o_quo (w_qx)
    );

    sfb_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_y),
        .i_den (w_den_y),
        .o_quo (w_qy)
    );

    // carry valid and frame result alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_vd[k] <= 1'b0;
        end else if (w_en) begin
            r_vd[0] <= r_v0;
            for (int k = 1; k < NW; k++) r_vd[k] <= r_vd[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fidx_d[0] <= r_fidx0;
            r_fok_d[0]  <= r_fok0;
            for (int k = 1; k < NW; k++) begin
                r_fidx_d[k] <= r_fidx_d[k-1];
                r_fok_d[k]  <= r_fok_d[k-1];
            end
        end
    end

    // flip the row and scale it by the image width
    assign w_sy = $signed({18'd0, i_cfg.image_height}) - sfb_pkg::SY_W'(1)
                - $signed({2'b00, w_qy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (w_en) begin
            r_vm <= r_vd[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sprod <= sfb_pkg::SPROD_W'(w_sy)
                     * sfb_pkg::SPROD_W'($signed({1'b0, i_cfg.image_width}));
            r_sx    <= w_qx;
            r_fidxm <= r_fidx_d[NW-1];
            r_fokm  <= r_fok_d[NW-1];
        end
    end

    // add the column and check the source bounds
    assign w_src = sfb_pkg::SRC_W'(r_sprod) + $signed({17'd0, r_sx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fidx <= r_fidxm;
            r_sidx <= w_src[sfb_pkg::SIDX_W-1:0];
            r_we   <= r_fokm && !w_src[sfb_pkg::SRC_W-1]
                      && (w_src < $signed({20'd0, i_cfg.source_area}));
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.frame_index  = r_fidx;
    assign o_out.source_index = r_sidx;
    assign o_out.write_enable = r_we;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scaled flipped blit address generator: drives
// destination pixels over random handshakes, predicts the address results
// and compares them in order across several register settings.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [sfb_pkg::FIDX_W-1:0] frame_index;
        logic [sfb_pkg::SIDX_W-1:0] source_index;
        logic                       write_enable;
    } t_addr;

    int errors = 0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int LATENCY = 34;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // Predicts the address results and holds them until the block returns them
    class addr_scoreboard;
        longint unsigned scr_w = 1024, scr_h = 768, img_w = 1, img_h = 1;
        longint unsigned org_x = 0, org_y = 0, tgt_w = 1, tgt_h = 1;
        t_addr pending[$];

        function void set_reg(sfb_pkg::t_reg_idx idx, logic [sfb_pkg::CFG_W-1:0] v);
            case (idx)
                sfb_pkg::REG_SCREEN_W: scr_w = v[sfb_pkg::SW_W-1:0];
                sfb_pkg::REG_SCREEN_H: scr_h = v[sfb_pkg::SW_W-1:0];
                sfb_pkg::REG_IMAGE_W:  img_w = v[sfb_pkg::IW_W-1:0];
                sfb_pkg::REG_IMAGE_H:  img_h = v[sfb_pkg::IW_W-1:0];
                sfb_pkg::REG_ORIGIN_X: org_x = v;
                sfb_pkg::REG_ORIGIN_Y: org_y = v;
                sfb_pkg::REG_TARGET_W: tgt_w = v;
                sfb_pkg::REG_TARGET_H: tgt_h = v;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [sfb_pkg::ROW_W-1:0] row,
                                 logic [sfb_pkg::ROW_W-1:0] col);
            longint unsigned tw, th, frame;
            longint sx, sy, src;
            t_addr a;
            tw = (tgt_w == 0) ? 1 : tgt_w;
            th = (tgt_h == 0) ? 1 : tgt_h;
            frame = (org_y + row) * scr_w + org_x + col;
            sx = longint'((col * img_w) / tw);
            sy = longint'(img_h) - 1 - longint'((row * img_h) / th);
            src = sy * longint'(img_w) + sx;
            a.frame_index = frame[sfb_pkg::FIDX_W-1:0];
            a.source_index = src[sfb_pkg::SIDX_W-1:0];
            a.write_enable = (frame < scr_w * scr_h) && src >= 0
                             && src < longint'(img_w * img_h);
            pending.push_back(a);
        endfunction

        task check_result(t_addr got);
            t_addr want;
            if (pending.size() == 0) begin
                report("unexpected result", got.frame_index, 0);
                return;
            end
            want = pending.pop_front();
            if (got.frame_index !== want.frame_index)
                report("frame_index", got.frame_index, want.frame_index);
            if (got.source_index !== want.source_index)
                report("source_index", got.source_index, want.source_index);
            if (got.write_enable !== want.write_enable)
                report("write_enable", got.write_enable, want.write_enable);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = 0;
    logic [sfb_pkg::CFG_W-1:0] i_cfg_data = 0;
    sfb_in_if  in_ch();
    sfb_out_if out_ch();

    scaled_flipped_blit_address_gen dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    addr_scoreboard sb = new();
    int send_idle = 22, recv_idle = 76;

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.dest_row = 0;
        in_ch.dest_col = 0;
        out_ch.ready = 0;
    end

    // Watch the output side: check every transfer, toggle ready at random
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("scaled_flipped_blit_address_gen verification failed");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.frame_index, out_ch.source_index,
                             out_ch.write_enable});
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Present one pixel, holding it until the transfer; valid stays up after it
    task automatic send_pixel(input logic [sfb_pkg::ROW_W-1:0] row,
                              input logic [sfb_pkg::ROW_W-1:0] col);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.dest_row <= row;
        in_ch.dest_col <= col;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_pixel(row, col);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic hold_sender();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        hold_sender();
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input sfb_pkg::t_reg_idx idx,
                             input logic [sfb_pkg::CFG_W-1:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    // Mostly in-rectangle pixels, some anywhere in the field range
    task automatic random_pixels(input int n);
        int k;
        logic [sfb_pkg::ROW_W-1:0] r, c;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(9) < 8) begin
                r = sfb_pkg::ROW_W'($urandom_range(sb.tgt_h == 0 ? 0 : sb.tgt_h - 1));
                c = sfb_pkg::ROW_W'($urandom_range(sb.tgt_w == 0 ? 0 : sb.tgt_w - 1));
            end else begin
                r = sfb_pkg::ROW_W'($urandom);
                c = sfb_pkg::ROW_W'($urandom);
            end
            send_pixel(r, c);
        end
    endtask

    task automatic setup(input int sw, sh, iw, ih, ox, oy, tw, th);
        write_reg(sfb_pkg::REG_SCREEN_W, sfb_pkg::CFG_W'(sw));
        write_reg(sfb_pkg::REG_SCREEN_H, sfb_pkg::CFG_W'(sh));
        write_reg(sfb_pkg::REG_IMAGE_W, sfb_pkg::CFG_W'(iw));
        write_reg(sfb_pkg::REG_IMAGE_H, sfb_pkg::CFG_W'(ih));
        write_reg(sfb_pkg::REG_ORIGIN_X, sfb_pkg::CFG_W'(ox));
        write_reg(sfb_pkg::REG_ORIGIN_Y, sfb_pkg::CFG_W'(oy));
        write_reg(sfb_pkg::REG_TARGET_W, sfb_pkg::CFG_W'(tw));
        write_reg(sfb_pkg::REG_TARGET_H, sfb_pkg::CFG_W'(th));
    endtask

    initial begin
        int p;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset settings, corners, out-of-range, zero sizes and all-ones registers
        send_pixel(0, 0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(767, 1023);
        send_pixel(768, 0);
        drain();
        setup(640, 480, 320, 240, 100, 50, 640, 480);
        send_pixel(0, 0);
        send_pixel(479, 639);
        send_pixel(240, 320);
        send_pixel(480, 640);
        send_pixel(16'hFFFF, 0);
        send_pixel(0, 16'hFFFF);
        drain();
        setup(0, 0, 0, 0, 0, 0, 0, 0);
        send_pixel(0, 0);
        send_pixel(5, 7);
        send_pixel(16'hFFFF, 16'hFFFF);
        drain();
        setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF);
        send_pixel(0, 0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h5555);
        drain();

        // Random phases over the three idling mixes
        for (p = 0; p < 9; p++) begin
            if (p == 3) begin send_idle = 76; recv_idle = 22; end
            if (p == 6) begin send_idle = 0;  recv_idle = 0;  end
            case (p % 3)
                0: setup($urandom_range(1, 2048), $urandom_range(1, 2048),
                         $urandom_range(1, 4096), $urandom_range(1, 4096),
                         $urandom_range(0, 600), $urandom_range(0, 600),
                         $urandom_range(1, 3000), $urandom_range(1, 3000));
                1: setup(2048, 2048, 4096, 4096, 0, 0, 65535, 65535);
                default: setup($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom);
            endcase
            random_pixels(38);
            // Hold the sender until the pipe has emptied, then resume
            hold_sender();
            random_pixels(38);
            drain();
        end

        if (errors == 0) begin
            $display("scaled_flipped_blit_address_gen verification clean");
        end else begin
            $display("scaled_flipped_blit_address_gen verification failed");
        end
        $finish;
    end
endmodule
